[rtl/atr_pkg.sv]
`default_nettype none
package atr_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOGH,
    ST_LOGL,
    ST_LOGP,
    ST_TERM,
    ST_LN,
    ST_RDOLD,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } state_t;

  localparam logic CFG_USE_LOG = 1'b0;
  localparam logic CFG_WINDOW = 1'b1;

  // Operand selects for the log unit.
  localparam logic [1:0] LOG_SEL_HIGH = 2'd0;
  localparam logic [1:0] LOG_SEL_LOW = 2'd1;
  localparam logic [1:0] LOG_SEL_CLOSE = 2'd2;

  localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the input bar
    logic log_start;   // start the log unit
    logic [1:0] log_sel; // high, low or previous close
    logic form_term;   // compute the true-range term
    logic ln_mul;      // scale the log2 term to ln
    logic rd_old;      // read the oldest ring entry
    logic update;      // update the sum and ring
    logic div_start;   // start the divider
    logic finish;      // form the result
    logic clear;       // clear the window
  } cmd_t;

  typedef struct packed {
    logic log_done;
    logic div_done;
    logic zero_window;
    logic need_pc;
    logic log_mode;
    logic error;
    logic full_after;  // window will be full after this term
  } status_t;

endpackage
`default_nettype wire

[rtl/atr_ctrl.sv]
`default_nettype none
module atr_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_fire,
  input  wire logic             out_fire,
  input  wire atr_pkg::status_t st,
  output atr_pkg::cmd_t         cmd,
  output logic                  busy,
  output logic                  out_valid
);

  atr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= atr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      atr_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (in_fire) begin
          cmd.load = 1'b1;
          state_next = atr_pkg::ST_LOGH;
        end
      end
      atr_pkg::ST_LOGH: begin
        if (st.log_mode && !st.error) begin
          cmd.log_start = 1'b1;
          cmd.log_sel = atr_pkg::LOG_SEL_HIGH;
          state_next = atr_pkg::ST_LOGL;
        end else begin
          state_next = atr_pkg::ST_TERM;
        end
      end
      atr_pkg::ST_LOGL: begin
        if (st.log_done) begin
          cmd.log_start = 1'b1;
          cmd.log_sel = atr_pkg::LOG_SEL_LOW;
          state_next = atr_pkg::ST_LOGP;
        end
      end
      atr_pkg::ST_LOGP: begin
        if (st.log_done) begin
          if (st.need_pc) begin
            cmd.log_start = 1'b1;
            cmd.log_sel = atr_pkg::LOG_SEL_CLOSE;
          end
          state_next = atr_pkg::ST_TERM;
        end
      end
      atr_pkg::ST_TERM: begin
        if (st.log_done) begin
          cmd.form_term = 1'b1;
          state_next = atr_pkg::ST_LN;
        end
      end
      atr_pkg::ST_LN: begin
        cmd.ln_mul = 1'b1;
        state_next = atr_pkg::ST_RDOLD;
      end
      atr_pkg::ST_RDOLD: begin
        cmd.rd_old = 1'b1;
        state_next = atr_pkg::ST_SUM;
      end
      atr_pkg::ST_SUM: begin
        cmd.update = 1'b1;
        if (!st.zero_window && st.need_pc && !st.error && st.full_after) begin
          cmd.div_start = 1'b1;
          state_next = atr_pkg::ST_DIV;
        end else begin
          state_next = atr_pkg::ST_OUT;
          cmd.finish = 1'b1;
        end
      end
      atr_pkg::ST_DIV: begin
        if (st.div_done) begin
          cmd.finish = 1'b1;
          state_next = atr_pkg::ST_OUT;
        end
      end
      atr_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_fire) state_next = atr_pkg::ST_IDLE;
      end
      default: state_next = atr_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[rtl/atr_path.sv]
`default_nettype none
module atr_path #(
  parameter int MAX_WINDOW = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire atr_pkg::cmd_t    cmd,
  output atr_pkg::status_t      st,
  input  wire logic [31:0]      bar_high,
  input  wire logic [31:0]      bar_low,
  input  wire logic [31:0]      bar_close,
  input  wire logic             cfg_fire,
  input  wire logic [0:0]       cfg_index,
  input  wire logic [6:0]       cfg_data,
  output logic [31:0]           avg_range,
  output logic                  result_valid,
  output logic                  domain_error
);

  localparam int PW = $clog2(MAX_WINDOW);
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int SW = 34 + PW + 1;
  localparam int DCW = $clog2(SW + 1);
  localparam logic [31:0] LN2_Q32_W = atr_pkg::LN2_Q32;

  logic              use_log;
  logic [6:0]        window_length;
  logic [31:0]       hi, lo, pc, cl;
  logic              have_prev;
  logic [CW-1:0]     held;
  logic [PW-1:0]     ptr;
  logic signed [SW-1:0] wsum;
  logic signed [33:0] ring [MAX_WINDOW];
  logic signed [33:0] old_term;
  logic signed [33:0] term;
  logic signed [33:0] lh, ll, lp;
  logic              err;
  logic [CW-1:0]     len;

  // Effective window length.
  always_comb begin
    if (32'(window_length) > 32'(MAX_WINDOW)) len = CW'(MAX_WINDOW);
    else len = CW'(window_length);
  end

  // ---------------- log unit: one squaring per cycle ----------------
  logic [31:0] lx;
  logic [32:0] m;
  logic [4:0]  lbit;
  logic [15:0] frac;
  logic signed [33:0] lint;
  logic        lbusy;
  logic [1:0]  lsel;
  logic [4:0]  topb;
  logic [65:0] sq;
  logic [34:0] msq;

  always_comb begin
    unique case (cmd.log_sel)
      atr_pkg::LOG_SEL_HIGH: lx = hi;
      atr_pkg::LOG_SEL_LOW: lx = lo;
      default: lx = pc;
    endcase
    topb = 5'd0;
    for (int i = 1; i < 32; i++) if (lx[i]) topb = 5'(i);
    sq = 66'(m) * 66'(m);
    msq = 35'(sq >> 31);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lbusy <= 1'b0;
    end else if (cmd.log_start) begin
      lbusy <= 1'b1;
      lsel <= cmd.log_sel;
      m <= 33'({1'b0, lx} << (5'd31 - topb));
      lint <= (34'(signed'({1'b0, topb})) - 34'sd16) <<< 16;
      frac <= '0;
      lbit <= 5'd15;
    end else if (lbusy) begin
      if (msq[34:32] != 3'd0) begin
        frac[lbit[3:0]] <= 1'b1;
        m <= msq[33:1];
      end else begin
        m <= msq[32:0];
      end
      if (lbit == 5'd0) lbusy <= 1'b0;
      lbit <= lbit - 5'd1;
    end
  end

  logic lbusy_d;
  always_ff @(posedge clk) begin
    if (rst) lbusy_d <= 1'b0;
    else lbusy_d <= lbusy;
    if (lbusy_d && !lbusy) begin
      unique case (lsel)
        atr_pkg::LOG_SEL_HIGH: lh <= lint | 34'(frac);
        atr_pkg::LOG_SEL_LOW: ll <= lint | 34'(frac);
        default: lp <= lint | 34'(frac);
      endcase
    end
  end
  wire log_done = !lbusy && !lbusy_d;

  // ---------------- term formation ----------------
  logic signed [33:0] d1, d2, d3, mx;
  logic signed [33:0] a1, a2, a3;
  always_comb begin
    if (use_log) begin
      a1 = lh - ll; a2 = lh - lp; a3 = lp - ll;
    end else begin
      a1 = $signed({2'b0, hi}) - $signed({2'b0, lo});
      a2 = $signed({2'b0, hi}) - $signed({2'b0, pc});
      a3 = $signed({2'b0, pc}) - $signed({2'b0, lo});
    end
    d1 = a1; d2 = a2; d3 = a3;
    if (len == '0 || !have_prev) mx = d1;
    else begin
      mx = (d1 > d2) ? d1 : d2;
      if (d3 > mx) mx = d3;
    end
  end

  logic signed [33:0] rawd;
  logic [33:0] mag;
  logic [65:0] prod;
  logic [33:0] rmag;
  always_comb begin
    mag = rawd[33] ? 34'(-rawd) : 34'(rawd);
    prod = 66'(mag) * 66'(LN2_Q32_W) + (66'd1 << 31);
    rmag = 34'(prod >> 32);
  end

  always_ff @(posedge clk) begin
    if (cmd.form_term) rawd <= mx;
    if (cmd.ln_mul) begin
      if (use_log) term <= rawd[33] ? -$signed(rmag) : $signed(rmag);
      else term <= rawd;
    end
  end

  // ---------------- ring, sum, divider ----------------
  // Oldest slot is ptr - len, wrapped into the ring.
  logic [PW-1:0] old_idx;
  logic [CW:0]   old_sum;
  always_comb begin
    old_sum = (CW+1)'(ptr) + (CW+1)'(MAX_WINDOW) - (CW+1)'(len);
    if (old_sum >= (CW+1)'(MAX_WINDOW)) old_idx = PW'(old_sum - (CW+1)'(MAX_WINDOW));
    else old_idx = PW'(old_sum);
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_old) old_term <= ring[old_idx];
    if (cmd.update && !err && have_prev && len != '0) ring[ptr] <= term;
  end

  logic full_now;
  assign full_now = held >= len;

  logic [SW-1:0] dq;
  logic [CW-1:0] drem;
  logic [SW-1:0] dmag;
  logic          dneg;
  logic [DCW-1:0] dcnt;
  logic          dbusy;
  logic [CW:0]   dtrial;
  logic signed [SW-1:0] wsum_new;

  always_comb begin
    wsum_new = wsum + SW'(term) - (full_now ? SW'(old_term) : SW'(0));
    dtrial = {drem, dmag[SW-1]} - {1'b0, len};
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      held <= '0;
      ptr <= '0;
      wsum <= '0;
    end else if (cmd.update && !err && have_prev && len != '0) begin
      if (!full_now) held <= held + CW'(1);
      wsum <= wsum_new;
      ptr <= (ptr == PW'(MAX_WINDOW - 1)) ? '0 : ptr + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
    end else if (cmd.div_start) begin
      dbusy <= 1'b1;
      dneg <= wsum_new[SW-1];
      dmag <= wsum_new[SW-1] ? SW'(-wsum_new) : SW'(wsum_new);
      drem <= '0;
      dq <= '0;
      dcnt <= DCW'(SW);
    end else if (dbusy) begin
      if (!dtrial[CW]) begin
        drem <= dtrial[CW-1:0];
        dq <= {dq[SW-2:0], 1'b1};
      end else begin
        drem <= {drem[CW-2:0], dmag[SW-1]};
        dq <= {dq[SW-2:0], 1'b0};
      end
      dmag <= {dmag[SW-2:0], 1'b0};
      dcnt <= dcnt - DCW'(1);
      if (dcnt == DCW'(1)) dbusy <= 1'b0;
    end
  end

  // ---------------- capture and result ----------------
  logic signed [SW:0] qs;
  always_comb qs = dneg ? -$signed({1'b0, dq}) : $signed({1'b0, dq});

  always_ff @(posedge clk) begin
    if (rst) begin
      use_log <= 1'b0;
      window_length <= 7'd14;
      have_prev <= 1'b0;
      pc <= '0;
    end else begin
      if (cfg_fire) begin
        if (cfg_index == atr_pkg::CFG_USE_LOG) use_log <= cfg_data[0];
        else window_length <= cfg_data;
      end
      if (cmd.finish) begin
        pc <= cl;
        have_prev <= 1'b1;
      end
    end
    if (cmd.load) begin
      hi <= bar_high;
      lo <= bar_low;
      cl <= bar_close;
      // A zero price only matters where its log is actually needed.
      err <= use_log && ((len == '0) ? (bar_high == '0 || bar_low == '0) :
             (have_prev && (bar_high == '0 || bar_low == '0 || pc == '0)));
    end
    if (cmd.finish) begin
      domain_error <= err;
      if (err || (len != '0 && !have_prev)) begin
        avg_range <= '0;
        result_valid <= 1'b0;
      end else if (len == '0) begin
        avg_range <= (term > 34'sh7FFFFFFF) ? 32'h7FFFFFFF :
                     (term < -34'sh80000000) ? 32'h80000000 : term[31:0];
        result_valid <= 1'b1;
      end else if (dbusy == 1'b0 && cmd.update == 1'b0) begin
        avg_range <= (qs > (SW+1)'(32'sh7FFFFFFF)) ? 32'h7FFFFFFF :
                     (qs < -(SW+1)'(33'sh80000000)) ? 32'h80000000 : qs[31:0];
        result_valid <= 1'b1;
      end else begin
        avg_range <= '0;
        result_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    st.log_done = log_done;
    st.div_done = !dbusy;
    st.zero_window = (len == '0);
    st.need_pc = have_prev && len != '0;
    st.log_mode = use_log;
    st.error = err;
    st.full_after = (held + CW'(1)) >= len || full_now;
  end

endmodule
`default_nettype wire

[rtl/average_true_range.sv]
// Average true range over a moving window of price bars.
// A bar runs straight to its result without a division; with a full window it
// also goes through the serial divider, and in log mode first through three
// log evaluations. One bar at a time: the next is taken at the earliest in the
// cycle after the result transfer; output stalls hold it back.
// Synchronous reset clears the window and previous close, use_log 0, window 14.
`default_nettype none
module average_true_range #(
  parameter int MAX_WINDOW = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // s_axis_tdata fields from bit 0: bar_high, bar_low, bar_close.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [95:0] s_axis_tdata,
  // m_axis_tdata fields from bit 0: avg_range.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,
  // m_axis_tuser fields from bit 0: result_valid, domain_error.
  output logic [1:0]       m_axis_tuser,
  // Configuration write channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [6:0]  cfg_data
);

  atr_pkg::cmd_t    cmd;
  atr_pkg::status_t st;
  logic busy;
  logic [31:0] avg_range;
  logic result_valid, domain_error;

  wire in_fire = s_axis_tvalid && s_axis_tready;
  wire out_fire = m_axis_tvalid && m_axis_tready;
  wire cfg_fire = cfg_valid && cfg_ready;

  // Register writes are taken only while idle, and a pending write goes
  // ahead of a bar offered in the same cycle.
  assign s_axis_tready = !busy && !cfg_valid;
  assign cfg_ready = !busy;

  // Any register write clears the window contents.
  atr_pkg::cmd_t cmd_p;
  always_comb begin
    cmd_p = cmd;
    cmd_p.clear = cfg_fire;
  end

  atr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_fire(out_fire),
    .st(st), .cmd(cmd), .busy(busy), .out_valid(m_axis_tvalid)
  );

  atr_path #(.MAX_WINDOW(MAX_WINDOW)) u_path (
    .clk(clk), .rst(rst), .cmd(cmd_p), .st(st),
    .bar_high(s_axis_tdata[31:0]), .bar_low(s_axis_tdata[63:32]),
    .bar_close(s_axis_tdata[95:64]),
    .cfg_fire(cfg_fire), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .avg_range(avg_range), .result_valid(result_valid), .domain_error(domain_error)
  );

  assign m_axis_tdata = avg_range;
  assign m_axis_tuser = {domain_error, result_valid};

  // A new bar is never taken while a result waits.
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("bar accepted during output");
  // An error result never claims validity.
  a_err_not_valid: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && domain_error) |-> !result_valid) else $error("error with valid");
  // An invalid result carries zero.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !result_valid) |-> (avg_range == 32'd0))
    else $error("invalid result not zero");

endmodule
`default_nettype wire
